// ----- sv/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// ARP address cache package
// Shared widths, codes and defaults for the ARP address cache.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

    localparam int ENTRIES_DEFAULT = 8;
    localparam int IP_W            = 32;
    localparam int MAC_W           = 48;
    localparam int INDEX_W         = 3;
    localparam int OUTCOME_W       = 2;

    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 3;

    typedef enum logic
    {
        OP_LOOKUP = 1'b0,
        OP_UPDATE = 1'b1
    } op_t;

    typedef enum logic [OUTCOME_W-1:0]
    {
        OUT_REFRESHED  = 2'd0,
        OUT_INSERTED   = 2'd1,
        OUT_NOT_FORCED = 2'd2,
        OUT_FULL       = 2'd3
    } outcome_t;

endpackage

`default_nettype wire

// ----- sv/arp_address_cache.sv -----
// ----------------------------------------------------------------------------
// ARP address cache
// Associative table that maps IPv4 addresses to MAC addresses by a serial scan.
// ----------------------------------------------------------------------------
// One item is a lookup or an update. The entries are scanned one per cycle
// through a single read port of the table memory and a single IP comparator.
// The result is registered once every entry has been compared, or earlier
// when an entry matches, since the first matching entry ends the scan. The
// block is ready again in the cycle after the result is registered, so a new
// item is accepted only once the result of the previous one is registered.
// The result sits in an output register, so the next item is accepted and
// scanned while the previous result still waits; its result is then held
// back until the waiting result is taken. Entries are marked valid by
// flip-flops that reset clears at once, so no clearing pass is needed.
`default_nettype none

module arp_address_cache #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // ip_address[31:0], mac_address[79:32]
    input  wire logic [arpc_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0], force_insert[1]
    input  wire logic [arpc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // entry_index[2:0], mac_result[50:3], zero fill[55:51]
    output logic [arpc_pkg::M_TDATA_W-1:0]      m_tdata,
    // hit[0], update_outcome[2:1]
    output logic [arpc_pkg::M_TUSER_W-1:0]      m_tuser
);

    localparam int IDXW = $clog2(ENTRIES);
    localparam logic [IDXW-1:0] LAST = IDXW'(ENTRIES - 1);
    localparam int IPW  = arpc_pkg::IP_W;
    localparam int MACW = arpc_pkg::MAC_W;

    typedef enum logic [2:0]
    {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [MACW-1:0] mac_mem [ENTRIES];
    logic [IPW-1:0]  ip_mem  [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic [IDXW-1:0] rd_addr_reg, rd_addr_next;
    logic [IDXW-1:0] pend_idx_reg, pend_idx_next;
    logic            rd_pend_reg, rd_pend_next;
    logic            issue_done_reg, issue_done_next;
    logic [MACW-1:0] rd_mac_reg;
    logic [IPW-1:0]  rd_ip_reg;
    logic            rd_valid_reg;

    arpc_pkg::op_t   op_reg, op_next;
    logic [IPW-1:0]  ip_reg, ip_next;
    logic [MACW-1:0] mac_reg, mac_next;
    logic            force_reg, force_next;

    logic            match_found_reg, match_found_next;
    logic [IDXW-1:0] match_idx_reg, match_idx_next;
    logic [MACW-1:0] match_mac_reg, match_mac_next;
    logic            empty_found_reg, empty_found_next;
    logic [IDXW-1:0] empty_idx_reg, empty_idx_next;

    logic                          m_tvalid_reg, m_tvalid_next;
    logic                          hit_reg, hit_next;
    logic [arpc_pkg::INDEX_W-1:0]  index_reg, index_next;
    logic [MACW-1:0]               result_reg, result_next;
    arpc_pkg::outcome_t            outcome_reg, outcome_next;

    logic            wr_en;
    logic [IDXW-1:0] wr_idx;
    logic [MACW-1:0] eff_mac;
    logic [IPW-1:0]  eff_ip;

    assign eff_mac = rd_valid_reg ? rd_mac_reg : '0;
    assign eff_ip  = rd_valid_reg ? rd_ip_reg : '0;

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        rd_addr_next     = rd_addr_reg;
        pend_idx_next    = pend_idx_reg;
        rd_pend_next     = 1'b0;
        issue_done_next  = issue_done_reg;
        op_next          = op_reg;
        ip_next          = ip_reg;
        mac_next         = mac_reg;
        force_next       = force_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        match_mac_next   = match_mac_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        hit_next         = hit_reg;
        index_next       = index_reg;
        result_next      = result_reg;
        outcome_next     = outcome_reg;
        wr_en            = 1'b0;
        wr_idx           = match_idx_reg;
        s_tready         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next          = arpc_pkg::op_t'(s_tuser[0]);
                    force_next       = s_tuser[1];
                    ip_next          = s_tdata[IPW-1:0];
                    mac_next         = s_tdata[IPW+MACW-1:IPW];
                    rd_addr_next     = '0;
                    issue_done_next  = 1'b0;
                    match_found_next = 1'b0;
                    empty_found_next = 1'b0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    rd_pend_next  = 1'b1;
                    pend_idx_next = rd_addr_reg;
                    if (rd_addr_reg == LAST)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        rd_addr_next = rd_addr_reg + IDXW'(1);
                    end
                end
                if (rd_pend_reg)
                begin
                    if (!empty_found_reg && eff_mac == '0)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = pend_idx_reg;
                    end
                    if (eff_ip == ip_reg)
                    begin
                        match_found_next = 1'b1;
                        match_idx_next   = pend_idx_reg;
                        match_mac_next   = eff_mac;
                        rd_pend_next     = 1'b0;
                        state_next       = ST_FINISH;
                    end
                    else if (pend_idx_reg == LAST)
                    begin
                        rd_pend_next = 1'b0;
                        state_next   = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    hit_next      = match_found_reg;
                    index_next    = '0;
                    result_next   = '0;
                    outcome_next  = arpc_pkg::OUT_REFRESHED;
                    if (match_found_reg)
                    begin
                        index_next = arpc_pkg::INDEX_W'(match_idx_reg);
                    end
                    if (op_reg == arpc_pkg::OP_LOOKUP)
                    begin
                        if (match_found_reg)
                        begin
                            result_next = match_mac_reg;
                        end
                    end
                    else if (match_found_reg)
                    begin
                        wr_en  = 1'b1;
                        wr_idx = match_idx_reg;
                    end
                    else if (!force_reg)
                    begin
                        outcome_next = arpc_pkg::OUT_NOT_FORCED;
                    end
                    else if (!empty_found_reg)
                    begin
                        outcome_next = arpc_pkg::OUT_FULL;
                    end
                    else
                    begin
                        wr_en        = 1'b1;
                        wr_idx       = empty_idx_reg;
                        index_next   = arpc_pkg::INDEX_W'(empty_idx_reg);
                        outcome_next = arpc_pkg::OUT_INSERTED;
                    end
                    if (wr_en)
                    begin
                        valid_next[wr_idx] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            valid_reg       <= '0;
            rd_addr_reg     <= '0;
            rd_pend_reg     <= 1'b0;
            issue_done_reg  <= 1'b0;
            match_found_reg <= 1'b0;
            empty_found_reg <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            rd_addr_reg     <= rd_addr_next;
            rd_pend_reg     <= rd_pend_next;
            issue_done_reg  <= issue_done_next;
            match_found_reg <= match_found_next;
            empty_found_reg <= empty_found_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg  <= pend_idx_next;
        op_reg        <= op_next;
        ip_reg        <= ip_next;
        mac_reg       <= mac_next;
        force_reg     <= force_next;
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        empty_idx_reg <= empty_idx_next;
        hit_reg       <= hit_next;
        index_reg     <= index_next;
        result_reg    <= result_next;
        outcome_reg   <= outcome_next;
    end

    // A refresh matched on IP, so writing the query IP back leaves it unchanged.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mac_mem[wr_idx] <= mac_reg;
            ip_mem[wr_idx]  <= ip_reg;
        end
        rd_mac_reg   <= mac_mem[rd_addr_reg];
        rd_ip_reg    <= ip_mem[rd_addr_reg];
        rd_valid_reg <= valid_reg[rd_addr_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(arpc_pkg::M_TDATA_W - MACW - arpc_pkg::INDEX_W){1'b0}},
                       result_reg, index_reg};
    assign m_tuser  = {outcome_reg, hit_reg};

endmodule

`default_nettype wire

// ----- sv/arpc_checker.sv -----
// ----------------------------------------------------------------------------
// ARP address cache checker
// Port-level assertions for the ARP address cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [arpc_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [arpc_pkg::M_TUSER_W-1:0] m_tuser
);

    logic [arpc_pkg::OUTCOME_W-1:0] outcome;
    logic [arpc_pkg::INDEX_W-1:0]   index;
    logic [arpc_pkg::MAC_W-1:0]     mac_result;

    assign outcome    = m_tuser[2:1];
    assign index      = m_tdata[arpc_pkg::INDEX_W-1:0];
    assign mac_result = m_tdata[arpc_pkg::MAC_W+arpc_pkg::INDEX_W-1:arpc_pkg::INDEX_W];

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Stalled result item changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("Input accepted while an item was still being scanned.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> outcome == arpc_pkg::OUT_REFRESHED)
        else $error("A hit reported an insert or a failed update.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> mac_result == '0)
        else $error("A miss carried a nonzero MAC.");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (outcome == arpc_pkg::OUT_NOT_FORCED || outcome == arpc_pkg::OUT_FULL)
        |-> index == '0)
        else $error("A failed update reported a nonzero entry index.");

endmodule

bind arp_address_cache arpc_checker u_arpc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ----- sim/arpc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP address cache checker
// Watches both stream channels of the ARP address cache, keeps its own copy
// of the address table, predicts the result of every accepted item and
// compares each returned result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------

module arpc_tb_checker #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    // ip_address[31:0], mac_address[79:32]
    input  wire logic [arpc_pkg::S_TDATA_W-1:0] s_tdata,
    // operation[0], force_insert[1]
    input  wire logic [arpc_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    // entry_index[2:0], mac_result[50:3], zero fill[55:51]
    input  wire logic [arpc_pkg::M_TDATA_W-1:0] m_tdata,
    // hit[0], update_outcome[2:1]
    input  wire logic [arpc_pkg::M_TUSER_W-1:0] m_tuser,
    output int                                  fail_count,
    output int                                  pending
);

    localparam int IDX_W = arpc_pkg::INDEX_W;
    localparam int MAC_W = arpc_pkg::MAC_W;
    localparam int IP_W  = arpc_pkg::IP_W;
    localparam int TD_W  = arpc_pkg::M_TDATA_W;

    typedef struct packed
    {
        logic               hit;
        logic [IDX_W-1:0]   index;
        logic [MAC_W-1:0]   mac;
        arpc_pkg::outcome_t outcome;
    } cache_answer_t;

    logic [MAC_W-1:0] tbl_mac [ENTRIES];
    logic [IP_W-1:0]  tbl_ip  [ENTRIES];
    cache_answer_t    answers_due [$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s mismatch, got %0h, predicted %0h", $time, field, got, want);
        fail_count++;
    endtask

    // Scans the shadow table in entry order and applies the item to it.
    function automatic cache_answer_t resolve_request(input arpc_pkg::op_t op,
                                                      input logic [IP_W-1:0] ip,
                                                      input logic [MAC_W-1:0] mac,
                                                      input logic force_ins);
        cache_answer_t ans;
        int            match_at;
        int            empty_at;
        ans      = '{hit: 1'b0, index: '0, mac: '0, outcome: arpc_pkg::OUT_REFRESHED};
        match_at = -1;
        empty_at = -1;
        for (int k = 0; k < ENTRIES; k++)
        begin
            if (empty_at < 0 && tbl_mac[k] == '0)
                empty_at = k;
            if (tbl_ip[k] == ip)
            begin
                match_at = k;
                break;
            end
        end
        if (op == arpc_pkg::OP_LOOKUP)
        begin
            if (match_at >= 0)
            begin
                ans.hit   = 1'b1;
                ans.index = IDX_W'(match_at);
                ans.mac   = tbl_mac[match_at];
            end
        end
        else if (match_at >= 0)
        begin
            tbl_mac[match_at] = mac;
            ans.hit   = 1'b1;
            ans.index = IDX_W'(match_at);
        end
        else if (!force_ins)
            ans.outcome = arpc_pkg::OUT_NOT_FORCED;
        else if (empty_at < 0)
            ans.outcome = arpc_pkg::OUT_FULL;
        else
        begin
            tbl_mac[empty_at] = mac;
            tbl_ip[empty_at]  = ip;
            ans.index   = IDX_W'(empty_at);
            ans.outcome = arpc_pkg::OUT_INSERTED;
        end
        return ans;
    endfunction

    always @(posedge clk)
    begin
        cache_answer_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < ENTRIES; k++)
            begin
                tbl_mac[k] = '0;
                tbl_ip[k]  = '0;
            end
            answers_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (answers_due.size() == 0)
                    report_mismatch("unexpected result", 64'(m_tdata), 64'(m_tuser));
                else
                begin
                    want = answers_due.pop_front();
                    if (m_tuser[0] !== want.hit)
                        report_mismatch("hit", 64'(m_tuser[0]), 64'(want.hit));
                    if (m_tdata[IDX_W-1:0] !== want.index)
                        report_mismatch("entry_index", 64'(m_tdata[IDX_W-1:0]),
                                        64'(want.index));
                    if (m_tdata[IDX_W+MAC_W-1:IDX_W] !== want.mac)
                        report_mismatch("mac_result", 64'(m_tdata[IDX_W+MAC_W-1:IDX_W]),
                                        64'(want.mac));
                    if (m_tdata[TD_W-1:IDX_W+MAC_W] !== '0)
                        report_mismatch("tdata fill", 64'(m_tdata[TD_W-1:IDX_W+MAC_W]),
                                        64'd0);
                    if (m_tuser[2:1] !== want.outcome)
                        report_mismatch("update_outcome", 64'(m_tuser[2:1]),
                                        64'(want.outcome));
                end
            end
            if (s_tvalid && s_tready)
                answers_due.push_back(resolve_request(arpc_pkg::op_t'(s_tuser[0]),
                                                      s_tdata[IP_W-1:0],
                                                      s_tdata[IP_W+MAC_W-1:IP_W],
                                                      s_tuser[1]));
        end
        pending = answers_due.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ARP address cache testbench
// Drives lookups and updates into the ARP address cache, first a directed
// sequence through empty, refreshed, inserted and full cases, then random
// traffic over a small address pool with varying idle rates on both sides.
// A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_SIZE   = 12;
    localparam int IP_W        = arpc_pkg::IP_W;
    localparam int MAC_W       = arpc_pkg::MAC_W;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [arpc_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic [arpc_pkg::S_TUSER_W-1:0] s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [arpc_pkg::M_TDATA_W-1:0] m_tdata;
    logic [arpc_pkg::M_TUSER_W-1:0] m_tuser;

    int          fail_count;
    int          pending;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold_left = 0;
    logic        rx_hold_req = 1'b0;
    int          cycle_count = 0;
    logic [31:0] ip_pool [POOL_SIZE];

    arp_address_cache u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    arpc_tb_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_left = 300;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input arpc_pkg::op_t op, input logic [IP_W-1:0] ip,
                             input logic [MAC_W-1:0] mac, input logic force_ins);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mac, ip};
        s_tuser  <= {force_ins, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_item();
        arpc_pkg::op_t    op;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic             force_ins;
        int               pick;
        op        = arpc_pkg::op_t'($urandom_range(0, 1));
        ip        = ($urandom_range(0, 99) < 70) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                 : $urandom;
        pick      = $urandom_range(0, 99);
        if (pick < 20)
            mac = '0;
        else if (pick < 30)
            mac = '1;
        else
            mac = {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
        force_ins = ($urandom_range(0, 99) < 75);
        send_item(op, ip, mac, force_ins);
    endtask

    initial
    begin
        ip_pool[0] = 32'h0000_0000;
        ip_pool[1] = 32'hFFFF_FFFF;
        ip_pool[2] = 32'hC0A8_0001;
        ip_pool[3] = 32'hC0A8_0002;
        ip_pool[4] = 32'h0A00_0001;
        for (int k = 5; k < POOL_SIZE; k++)
            ip_pool[k] = $urandom;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed sequence from a freshly cleared table.
        send_item(arpc_pkg::OP_LOOKUP, 32'h0000_0000, 48'h0, 1'b0);
        send_item(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[2], 48'h1234_5678_9ABC, 1'b0);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[2], 48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(arpc_pkg::OP_LOOKUP, ip_pool[2], 48'h0, 1'b0);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[2], 48'h0000_0000_0001, 1'b0);
        send_item(arpc_pkg::OP_UPDATE, 32'h0000_0000, 48'h8000_0000_0000, 1'b1);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[3], 48'h0, 1'b1);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[4], 48'h5555_AAAA_5555, 1'b1);
        send_item(arpc_pkg::OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
        for (int k = 5; k < 9; k++)
            send_item(arpc_pkg::OP_UPDATE, ip_pool[k], 48'hAAAA_5555_0000 + 48'(k), 1'b1);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[9], 48'h0F0F_F0F0_0F0F, 1'b1);
        send_item(arpc_pkg::OP_LOOKUP, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1);
        send_item(arpc_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 48'h0, 1'b0);
        send_item(arpc_pkg::OP_LOOKUP, ip_pool[3], 48'h0, 1'b0);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[5], 48'h0, 1'b1);
        send_item(arpc_pkg::OP_UPDATE, ip_pool[10], 48'hFEDC_BA98_7654, 1'b1);
        send_item(arpc_pkg::OP_LOOKUP, ip_pool[10], 48'h0, 1'b0);
        send_item(arpc_pkg::OP_LOOKUP, ip_pool[11], 48'h0, 1'b0);

        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
            rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 31 : 0;
            for (int n = 0; n < 410; n++)
            begin
                if ((phase == 0 && n == 100) || (phase == 2 && n == 50))
                    rx_hold_req = 1'b1;
                if (phase == 1 && n == 150)
                begin
                    s_tvalid <= 1'b0;
                    @(negedge clk);
                    while (pending != 0)
                        @(negedge clk);
                end
                send_random_item();
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
